### rtl/rse_pkg.sv
// ----------------------------------------------------------------------------
// rse_pkg
// shared types, codes and constants of the rpn stack evaluator
// ----------------------------------------------------------------------------
package rse_pkg;

   localparam int RSE_STACK_DEPTH = 128;
   localparam int WORD_W          = 32;
   localparam int FUNC_W          = 3;
   localparam int STATUS_W        = 2;

   // token function codes
   localparam logic [FUNC_W-1:0] FUNC_PUSH = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_ADD  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_SUB  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_MUL  = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_DIV  = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_REM  = 3'd5;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_UNDER   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVER    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_DIVZERO = 2'd3;

   typedef struct packed {
      logic [FUNC_W-1:0]        func;
      logic signed [WORD_W-1:0] literal;
      logic                     expr_end;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] top_value;
      logic [STATUS_W-1:0]      status;
      logic                     stack_empty;
      logic                     expr_done;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIV,
      ST_RESULT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic exec;
      logic div_commit;
      logic load_rsp;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_needed;
      logic div_done;
   } sts_type;

endpackage

### rtl/rse_divider.sv
// ----------------------------------------------------------------------------
// rse_divider
// iterative signed truncating divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rse_divider
   import rse_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [WORD_W-1:0] dividend,
   input  logic [WORD_W-1:0] divisor,
   input  logic              want_rem,
   output logic              done,
   output logic [WORD_W-1:0] result
);

   localparam int CNT_W = $clog2(WORD_W + 1);

   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              fix_ff, fix_in;
   logic              done_ff, done_in;
   logic [WORD_W-1:0] rem_ff, rem_in;
   logic [WORD_W-1:0] quo_ff, quo_in;
   logic [WORD_W-1:0] dsr_ff, dsr_in;
   logic              neg_q_ff, neg_q_in;
   logic              neg_r_ff, neg_r_in;
   logic              want_rem_ff, want_rem_in;
   logic [WORD_W-1:0] result_ff, result_in;
   logic [WORD_W:0]   shifted;
   logic [WORD_W:0]   diff;

   always_comb begin
      shifted     = {rem_ff, quo_ff[WORD_W-1]};
      diff        = shifted - {1'b0, dsr_ff};
      cnt_in      = cnt_ff;
      fix_in      = 1'b0;
      done_in     = 1'b0;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      dsr_in      = dsr_ff;
      neg_q_in    = neg_q_ff;
      neg_r_in    = neg_r_ff;
      want_rem_in = want_rem_ff;
      result_in   = result_ff;
      if (start) begin
         // magnitudes, signs kept for the final fix-up
         rem_in      = '0;
         quo_in      = dividend[WORD_W-1] ? (WORD_W'(0) - dividend) : dividend;
         dsr_in      = divisor[WORD_W-1] ? (WORD_W'(0) - divisor) : divisor;
         neg_r_in    = dividend[WORD_W-1];
         neg_q_in    = dividend[WORD_W-1] ^ divisor[WORD_W-1];
         want_rem_in = want_rem;
         cnt_in      = CNT_W'(WORD_W);
      end else if (cnt_ff != '0) begin
         if (!diff[WORD_W]) begin
            rem_in = diff[WORD_W-1:0];
            quo_in = {quo_ff[WORD_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[WORD_W-1:0];
            quo_in = {quo_ff[WORD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         fix_in = (cnt_ff == CNT_W'(1));
      end
      if (fix_ff) begin
         done_in = 1'b1;
         if (want_rem_ff) begin
            result_in = neg_r_ff ? (WORD_W'(0) - rem_ff) : rem_ff;
         end else begin
            result_in = neg_q_ff ? (WORD_W'(0) - quo_ff) : quo_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         fix_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         fix_ff  <= fix_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      dsr_ff      <= dsr_in;
      neg_q_ff    <= neg_q_in;
      neg_r_ff    <= neg_r_in;
      want_rem_ff <= want_rem_in;
      result_ff   <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

### rtl/rse_datapath.sv
// ----------------------------------------------------------------------------
// rse_datapath
// operand stack, cached top of stack, arithmetic and response register
// ----------------------------------------------------------------------------
module rse_datapath
   import rse_pkg::*;
#(
   parameter int STACK_DEPTH = RSE_STACK_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   output sts_type sts,
   input  req_type req_data,
   output rsp_type rsp_data
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int DW = $clog2(STACK_DEPTH + 1);

   // entries below the top of stack; the top itself lives in top_ff
   logic [WORD_W-1:0] stack_mem [STACK_DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   req_type             req_ff;
   logic [WORD_W-1:0]   top_ff, top_in;
   logic [DW-1:0]       depth_ff, depth_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   rsp_type             rsp_data_ff;

   logic [DW-1:0]       depth_m1, depth_m2;
   logic [AW-1:0]       wr_addr, rd_addr;
   logic                mem_we;
   logic                has_two, full;
   logic                push_ok, alu_ok, div_needed;
   logic [STATUS_W-1:0] status_next;
   logic [WORD_W-1:0]   alu_res;
   logic                div_done;
   logic [WORD_W-1:0]   div_result;

   assign depth_m1 = depth_ff - DW'(1);
   assign depth_m2 = depth_ff - DW'(2);
   assign wr_addr  = depth_m1[AW-1:0];
   assign rd_addr  = depth_m2[AW-1:0];
   assign has_two  = (depth_ff >= DW'(2));
   assign full     = (depth_ff == DW'(STACK_DEPTH));

   // token decode, operand a from memory, operand b is the cached top
   always_comb begin
      status_next = STATUS_OK;
      push_ok     = 1'b0;
      alu_ok      = 1'b0;
      div_needed  = 1'b0;
      unique case (req_ff.func) inside
         FUNC_PUSH: begin
            if (full) status_next = STATUS_OVER;
            else      push_ok     = 1'b1;
         end
         FUNC_ADD, FUNC_SUB, FUNC_MUL: begin
            if (!has_two) status_next = STATUS_UNDER;
            else          alu_ok      = 1'b1;
         end
         FUNC_DIV, FUNC_REM: begin
            if (!has_two)            status_next = STATUS_UNDER;
            else if (top_ff == '0)   status_next = STATUS_DIVZERO;
            else                     div_needed  = 1'b1;
         end
         default: ;
      endcase
   end

   always_comb begin
      unique case (req_ff.func)
         FUNC_SUB: alu_res = rd_data_ff - top_ff;
         FUNC_MUL: alu_res = rd_data_ff * top_ff;
         default:  alu_res = rd_data_ff + top_ff;
      endcase
   end

   assign mem_we = cmd.exec && push_ok && (depth_ff != '0);

   always_ff @(posedge clock) begin
      if (mem_we) stack_mem[wr_addr] <= top_ff;
      rd_data_ff <= stack_mem[rd_addr];
   end

   rse_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.exec && div_needed),
      .dividend (rd_data_ff),
      .divisor  (top_ff),
      .want_rem (req_ff.func == FUNC_REM),
      .done     (div_done),
      .result   (div_result)
   );

   always_comb begin
      top_in    = top_ff;
      depth_in  = depth_ff;
      status_in = status_ff;
      if (cmd.exec) begin
         status_in = status_next;
         if (push_ok) begin
            top_in   = req_ff.literal;
            depth_in = depth_ff + DW'(1);
         end else if (alu_ok) begin
            top_in   = alu_res;
            depth_in = depth_m1;
         end
      end
      if (cmd.div_commit) begin
         top_in   = div_result;
         depth_in = depth_m1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) depth_ff <= '0;
      else       depth_ff <= depth_in;
   end

   always_ff @(posedge clock) begin
      top_ff    <= top_in;
      status_ff <= status_in;
      if (cmd.accept) req_ff <= req_data;
      if (cmd.load_rsp) begin
         rsp_data_ff.top_value   <= (depth_ff == '0) ? '0 : top_ff;
         rsp_data_ff.status      <= status_ff;
         rsp_data_ff.stack_empty <= (depth_ff == '0);
         rsp_data_ff.expr_done   <= req_ff.expr_end;
      end
   end

   assign sts.div_needed = div_needed;
   assign sts.div_done   = div_done;
   assign rsp_data       = rsp_data_ff;

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DW'(STACK_DEPTH))
      else $error("stack depth beyond capacity");

   a_commit_pops: assert property (@(posedge clock) disable iff (reset)
      cmd.div_commit |=> depth_ff == $past(depth_m1))
      else $error("divide commit did not pop one operand");

   a_empty_top_zero: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp && (depth_ff == '0) |=> rsp_data_ff.top_value == '0)
      else $error("empty stack reported a nonzero top");

endmodule

### rtl/rse_ctrl.sv
// ----------------------------------------------------------------------------
// rse_ctrl
// token sequencer and response valid register
// ----------------------------------------------------------------------------
module rse_ctrl
   import rse_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_EXEC;
         ST_EXEC:   state_in = sts.div_needed ? ST_DIV : ST_RESULT;
         ST_DIV:    if (sts.div_done) state_in = ST_RESULT;
         ST_RESULT: if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall      = (state_ff != ST_IDLE);
      cmd.accept     = (state_ff == ST_IDLE) && req_valid;
      cmd.exec       = (state_ff == ST_EXEC);
      cmd.div_commit = (state_ff == ST_DIV) && sts.div_done;
      cmd.load_rsp   = (state_ff == ST_RESULT) && rsp_free;
      rsp_valid_in   = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (cmd.load_rsp) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || !rsp_stall))
      else $error("response overwritten while stalled");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      sts.div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside divide state");

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> state_ff == ST_EXEC)
      else $error("accepted request not executed next");

endmodule

### rtl/rpn_stack_evaluator.sv
// sequence: an accepted request is executed, then loaded into the response register
//   and rsp_valid rises; divide and remainder wait on the divider before the load
// a new request is accepted only after the previous response has been loaded, so the
//   sequencer and the iterative divider bound the request rate; a stalled response holds it
// reset: synchronous, clears stack depth, sequencer and response valid; no memory sweep
// ----------------------------------------------------------------------------
// rpn_stack_evaluator
// reverse polish stack calculator on signed 32-bit words with status reporting
// ----------------------------------------------------------------------------
module rpn_stack_evaluator
   import rse_pkg::*;
#(
   parameter int STACK_DEPTH = RSE_STACK_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   // request channel
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   // response channel
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // command and status between sequencer and datapath
   cmd_type cmd;
   sts_type sts;

   // sequencer: idle, execute token, wait on divider, hand off response
   rse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: stack memory with the top of stack cached in a register,
   // so an operator reads only one memory word; the response register
   // decouples the two channels, a new request is taken while it waits
   rse_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .sts      (sts),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule
